>>> design/mtep_pkg.sv
// Shared types, constants and helpers for the MIDI track event parser.
// No dependencies; imported by mtep_out_reg and midi_track_event_parser.
`timescale 1ns / 1ps

package mtep_pkg;

  localparam int TICK_BITS_DEF = 32;

  // Parse phases
  typedef enum logic [3:0] {
    PH_DELTA   = 4'd0,
    PH_STATUS  = 4'd1,
    PH_DATA1   = 4'd2,
    PH_DATA2   = 4'd3,
    PH_MTYPE   = 4'd4,
    PH_MLEN    = 4'd5,
    PH_MDATA   = 4'd6,
    PH_SXLEN   = 4'd7,
    PH_SXDATA  = 4'd8,
    PH_DISCARD = 4'd9
  } phase_t;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_CHANNEL = 3'd0,
    KIND_SYSEX   = 3'd1,
    KIND_TEMPO   = 3'd2,
    KIND_LOOP    = 3'd3,
    KIND_SX_NONE = 3'd4
  } kind_t;

  localparam logic [7:0] BYTE_META      = 8'hFF;
  localparam logic [7:0] BYTE_SYSEX     = 8'hF0;
  localparam logic [7:0] BYTE_SYSEX_ESC = 8'hF7;
  localparam logic [7:0] META_TEMPO     = 8'h51;
  localparam logic [7:0] META_MARKER    = 8'h06;
  localparam logic [3:0] HI_PROG        = 4'hC;
  localparam logic [3:0] HI_PRESSURE    = 4'hD;
  localparam logic [3:0] MARKER_LEN     = 4'd9;

  // One result word as it leaves the block
  typedef struct packed {
    kind_t       kind;
    logic [31:0] tick;
    logic [7:0]  status;
    logic [7:0]  d1;
    logic [7:0]  d2;
    logic [23:0] tempo;
    logic        fin;
  } evt_t;

  function automatic logic one_data_byte(input logic [7:0] status);
    return (status[7:4] == HI_PROG) || (status[7:4] == HI_PRESSURE);
  endfunction

  // "loopStart", one character per index
  function automatic logic [7:0] marker_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h6C; // l
      4'd1:    c = 8'h6F; // o
      4'd2:    c = 8'h6F; // o
      4'd3:    c = 8'h70; // p
      4'd4:    c = 8'h53; // S
      4'd5:    c = 8'h74; // t
      4'd6:    c = 8'h61; // a
      4'd7:    c = 8'h72; // r
      4'd8:    c = 8'h74; // t
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> design/midi_track_event_parser.sv
// Top level of the MIDI track event parser: byte-wise track chunk decoder.
// Depends on mtep_pkg and mtep_out_reg.
`timescale 1ns / 1ps

//  channel  | direction | handshake           | payload
//  in_      | input     | in_valid/in_ready   | data_byte[7:0], track_last
//  out_     | output    | out_valid/out_ready | event kind, tick, status, data, tempo, final
//
// One byte is decoded per cycle while in_ready is high: the parse state and the result
// register update at the same edge the byte is taken, so a new byte can enter every
// cycle unless in_ready is low. A result is visible in the cycle after its byte.
// in_ready drops only while a result waits in the output register and out_ready is low.
// Reset (rst_n low, synchronous) returns the parser to "expect delta time",
// tick zero, no running status, and empties the output register.

module midi_track_event_parser #(
  parameter int TICK_BITS = mtep_pkg::TICK_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_track_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_kind,
  output logic [31:0] out_event_tick,
  output logic [7:0]  out_status_byte,
  output logic [7:0]  out_first_data,
  output logic [7:0]  out_second_data,
  output logic [23:0] out_tempo_value,
  output logic        out_sysex_final
);
  import mtep_pkg::*;

  // Parse state
  phase_t                 phase_r,     phase_nxt;
  logic [TICK_BITS-1:0]   tick_r,      tick_nxt;
  logic [7:0]             run_st_r,    run_st_nxt;
  logic [31:0]            varlen_r,    varlen_nxt;
  logic [7:0]             cur_st_r,    cur_st_nxt;
  logic [7:0]             mtype_r,     mtype_nxt;
  logic [31:0]            remain_r,    remain_nxt;
  logic [31:0]            decl_len_r,  decl_len_nxt;
  logic [3:0]             seen_r,      seen_nxt;
  logic [7:0]             held_d1_r,   held_d1_nxt;
  logic [23:0]            tempo_r,     tempo_nxt;
  logic                   mmatch_r,    mmatch_nxt;

  logic        in_fire;
  logic        slot_free;
  logic        res_valid;
  evt_t        res;
  evt_t        out_evt;

  logic        more;
  logic [31:0] vl_shift;
  logic [31:0] remain_dec;
  logic        mmatch_upd;

  assign in_ready = slot_free;
  assign in_fire  = in_valid && in_ready;

  assign more       = in_data_byte[7];
  assign vl_shift   = {varlen_r[24:0], in_data_byte[6:0]};
  assign remain_dec = remain_r - 32'd1;
  assign mmatch_upd = mmatch_r && (in_data_byte == marker_char(seen_r));

  always_comb begin
    phase_nxt    = phase_r;
    tick_nxt     = tick_r;
    run_st_nxt   = run_st_r;
    varlen_nxt   = varlen_r;
    cur_st_nxt   = cur_st_r;
    mtype_nxt    = mtype_r;
    remain_nxt   = remain_r;
    decl_len_nxt = decl_len_r;
    seen_nxt     = seen_r;
    held_d1_nxt  = held_d1_r;
    tempo_nxt    = tempo_r;
    mmatch_nxt   = mmatch_r;

    res_valid  = 1'b0;
    res.kind   = KIND_CHANNEL;
    res.tick   = 32'(tick_r);
    res.status = 8'h00;
    res.d1     = 8'h00;
    res.d2     = 8'h00;
    res.tempo  = 24'h000000;
    res.fin    = 1'b0;

    unique case (phase_r)
      PH_DELTA: begin
        // Accumulate the delta time, add it to the tick on its last byte
        varlen_nxt = vl_shift;
        if (!more) begin
          tick_nxt   = tick_r + TICK_BITS'(vl_shift);
          varlen_nxt = 32'd0;
          phase_nxt  = PH_STATUS;
        end
      end

      PH_STATUS: begin
        if (more) begin
          if (in_data_byte == BYTE_META) begin
            run_st_nxt = 8'h00;
            phase_nxt  = PH_MTYPE;
          end else if (in_data_byte == BYTE_SYSEX || in_data_byte == BYTE_SYSEX_ESC) begin
            run_st_nxt = 8'h00;
            cur_st_nxt = in_data_byte;
            varlen_nxt = 32'd0;
            phase_nxt  = PH_SXLEN;
          end else begin
            cur_st_nxt = in_data_byte;
            phase_nxt  = PH_DATA1;
          end
        end else if (run_st_r == 8'h00) begin
          // Data byte with no running status: drop the rest of the track
          phase_nxt = PH_DISCARD;
        end else begin
          cur_st_nxt = run_st_r;
          if (one_data_byte(run_st_r)) begin
            res_valid  = 1'b1;
            res.status = run_st_r;
            res.d1     = in_data_byte;
            phase_nxt  = PH_DELTA;
          end else begin
            held_d1_nxt = in_data_byte;
            phase_nxt   = PH_DATA2;
          end
        end
      end

      PH_DATA1: begin
        if (one_data_byte(cur_st_r)) begin
          res_valid  = 1'b1;
          res.status = cur_st_r;
          res.d1     = in_data_byte;
          run_st_nxt = cur_st_r;
          phase_nxt  = PH_DELTA;
        end else begin
          held_d1_nxt = in_data_byte;
          phase_nxt   = PH_DATA2;
        end
      end

      PH_DATA2: begin
        res_valid  = 1'b1;
        res.status = cur_st_r;
        res.d1     = held_d1_r;
        res.d2     = in_data_byte;
        run_st_nxt = cur_st_r;
        phase_nxt  = PH_DELTA;
      end

      PH_MTYPE: begin
        mtype_nxt  = in_data_byte;
        varlen_nxt = 32'd0;
        phase_nxt  = PH_MLEN;
      end

      PH_MLEN: begin
        varlen_nxt = vl_shift;
        if (!more) begin
          decl_len_nxt = vl_shift;
          remain_nxt   = vl_shift;
          varlen_nxt   = 32'd0;
          seen_nxt     = 4'd0;
          tempo_nxt    = 24'h000000;
          mmatch_nxt   = 1'b1;
          phase_nxt    = (vl_shift == 32'd0) ? PH_DELTA : PH_MDATA;
        end
      end

      PH_MDATA: begin
        // Tempo: first three payload bytes, big endian
        if (mtype_r == META_TEMPO && seen_r < 4'd3) begin
          tempo_nxt = {tempo_r[15:0], in_data_byte};
          if (seen_r == 4'd2) begin
            res_valid = 1'b1;
            res.kind  = KIND_TEMPO;
            res.tempo = {tempo_r[15:0], in_data_byte};
          end
        end
        // Marker: compare text, fire on the ninth byte of a nine-byte meta
        if (mtype_r == META_MARKER && seen_r < MARKER_LEN) begin
          mmatch_nxt = mmatch_upd;
          if (seen_r == MARKER_LEN - 4'd1 && mmatch_upd &&
              decl_len_r == 32'(MARKER_LEN)) begin
            res_valid = 1'b1;
            res.kind  = KIND_LOOP;
          end
        end
        if (seen_r != 4'hF) begin
          seen_nxt = seen_r + 4'd1;
        end
        remain_nxt = remain_dec;
        if (remain_dec == 32'd0) begin
          phase_nxt = PH_DELTA;
        end
      end

      PH_SXLEN: begin
        varlen_nxt = vl_shift;
        if (!more) begin
          remain_nxt = vl_shift;
          varlen_nxt = 32'd0;
          if (cur_st_r == BYTE_SYSEX) begin
            // Prepend the start byte
            res_valid = 1'b1;
            res.kind  = KIND_SYSEX;
            res.d1    = BYTE_SYSEX;
            res.fin   = (vl_shift == 32'd0) || in_track_last;
          end else if (vl_shift == 32'd0 || in_track_last) begin
            res_valid = 1'b1;
            res.kind  = KIND_SX_NONE;
          end
          phase_nxt = (vl_shift == 32'd0) ? PH_DELTA : PH_SXDATA;
        end
      end

      PH_SXDATA: begin
        res_valid  = 1'b1;
        res.kind   = KIND_SYSEX;
        res.d1     = in_data_byte;
        res.fin    = (remain_r == 32'd1) || in_track_last;
        remain_nxt = remain_dec;
        if (remain_dec == 32'd0) begin
          phase_nxt = PH_DELTA;
        end
      end

      PH_DISCARD: begin
        // Hold until the track's last byte
      end

      default: begin
        phase_nxt = PH_DISCARD;
      end
    endcase

    // End of track: return the parse state to its reset value
    if (in_track_last) begin
      phase_nxt    = PH_DELTA;
      tick_nxt     = '0;
      run_st_nxt   = 8'h00;
      varlen_nxt   = 32'd0;
      cur_st_nxt   = 8'h00;
      mtype_nxt    = 8'h00;
      remain_nxt   = 32'd0;
      decl_len_nxt = 32'd0;
      seen_nxt     = 4'd0;
      held_d1_nxt  = 8'h00;
      tempo_nxt    = 24'h000000;
      mmatch_nxt   = 1'b1;
    end
  end

  // Advance the parse state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_DELTA;
      tick_r     <= '0;
      run_st_r   <= 8'h00;
      varlen_r   <= 32'd0;
      cur_st_r   <= 8'h00;
      mtype_r    <= 8'h00;
      remain_r   <= 32'd0;
      decl_len_r <= 32'd0;
      seen_r     <= 4'd0;
      held_d1_r  <= 8'h00;
      tempo_r    <= 24'h000000;
      mmatch_r   <= 1'b1;
    end else if (in_fire) begin
      phase_r    <= phase_nxt;
      tick_r     <= tick_nxt;
      run_st_r   <= run_st_nxt;
      varlen_r   <= varlen_nxt;
      cur_st_r   <= cur_st_nxt;
      mtype_r    <= mtype_nxt;
      remain_r   <= remain_nxt;
      decl_len_r <= decl_len_nxt;
      seen_r     <= seen_nxt;
      held_d1_r  <= held_d1_nxt;
      tempo_r    <= tempo_nxt;
      mmatch_r   <= mmatch_nxt;
    end
  end

  // Result register: loads on every accepted word, valid only if it made a result
  mtep_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_fire),
    .load_valid (res_valid),
    .load_evt   (res),
    .slot_free  (slot_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_evt    (out_evt)
  );

  assign out_event_kind  = out_evt.kind;
  assign out_event_tick  = out_evt.tick;
  assign out_status_byte = out_evt.status;
  assign out_first_data  = out_evt.d1;
  assign out_second_data = out_evt.d2;
  assign out_tempo_value = out_evt.tempo;
  assign out_sysex_final = out_evt.fin;

endmodule

>>> design/mtep_out_reg.sv
// Result register with valid/ready handshake for the MIDI track event parser.
// Depends on mtep_pkg (evt_t).
`timescale 1ns / 1ps

module mtep_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  logic          load_valid,
  input  mtep_pkg::evt_t load_evt,
  output logic          slot_free,
  output logic          out_valid,
  input  logic          out_ready,
  output mtep_pkg::evt_t out_evt
);
  import mtep_pkg::*;

  logic valid_r;
  evt_t evt_r;

  // Slot may be refilled when empty or being drained this cycle
  assign slot_free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= load_valid;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_valid) begin
      evt_r <= load_evt;
    end
  end

  assign out_valid = valid_r;
  assign out_evt   = evt_r;

endmodule
